// File: design/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the pooled bitmap id allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int ID_W      = 20;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 16;
  localparam int CMD_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ALLOC_ANY = 2'd0,
    OP_ALLOC_MIN = 2'd1,
    OP_FREE      = 2'd2,
    OP_CLAIM     = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            id_zero;
    logic [ID_W-1:0] vid;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic init_done;
  } front_stat_t;

endpackage

// File: design/pba_front.sv
// ----------------------------------------------------------------------------
// pba_front
// Accepts request transactions and turns them into queued commands.
// ----------------------------------------------------------------------------
module pba_front (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pba_pkg::op_e            op_i,
  input  logic [pba_pkg::ID_W-1:0] id_i,
  input  pba_pkg::front_stat_t    stat_i,
  output logic                    push_o,
  output pba_pkg::cmd_t           cmd_o
);
  import pba_pkg::*;

  logic id_zero;

  assign id_zero      = (id_i == '0);
  assign in_ready_o   = stat_i.init_done && !stat_i.full;
  assign push_o       = in_valid_i && in_ready_o;
  assign cmd_o.op     = op_i;
  assign cmd_o.id_zero = id_zero;
  // zero-based identifier, a zero minimum maps to pool 0
  assign cmd_o.vid    = id_zero ? '0 : id_i - ID_W'(1);

endmodule

// File: design/pba_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pba_cmd_fifo
// Short command queue between the front and the engine.
// ----------------------------------------------------------------------------
module pba_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pba_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output pba_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);
  import pba_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_FW = $clog2(CMD_DEPTH + 1);

  cmd_t              mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_FW-1:0] count_q;

  assign full_o  = (count_q == CNT_FW'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_FW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_FW'(1);
      end
    end
  end

endmodule

// File: design/pba_engine.sv
// ----------------------------------------------------------------------------
// pba_engine
// Executes commands against the bitmap and use-count memories and holds
// the result register.
// ----------------------------------------------------------------------------
module pba_engine #(
  parameter int POOLS          = 31,
  parameter int SLOTS_PER_POOL = 32768,
  parameter int WORDS_PER_POOL = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  pba_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  output logic                     init_done_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [pba_pkg::ID_W-1:0] result_id_o,
  output logic                     ok_o
);
  import pba_pkg::*;

  localparam int TOTAL = POOLS * WORDS_PER_POOL;
  localparam int AW    = $clog2(TOTAL);
  localparam int BW    = $clog2(TOTAL + 1);
  localparam int PW    = $clog2(POOLS + 1);
  localparam int PA    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int WW    = $clog2(WORDS_PER_POOL + 1);
  localparam int WA    = $clog2(WORDS_PER_POOL);
  localparam int SW    = $clog2(SLOTS_PER_POOL);

  localparam logic [PW-1:0]   POOLS_V  = PW'(POOLS);
  localparam logic [WW-1:0]   WORDS_V  = WW'(WORDS_PER_POOL);
  localparam logic [BW-1:0]   WORDS_B  = BW'(WORDS_PER_POOL);
  localparam logic [17:0]     WORDS_18 = 18'(WORDS_PER_POOL);
  localparam logic [ID_W-1:0] SLOTS_ID = ID_W'(SLOTS_PER_POOL);
  localparam logic [17:0]     SLOTS_18 = 18'(SLOTS_PER_POOL);
  localparam logic [16:0]     FULL_CNT = 17'(SLOTS_PER_POOL - 1);
  localparam logic [AW-1:0]   LAST_A   = AW'(TOTAL - 1);
  localparam logic [AW-1:0]   POOLS_A  = AW'(POOLS);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_LOCATE  = 8'b0000_0100,
    S_CNT_RD  = 8'b0000_1000,
    S_CNT_CHK = 8'b0001_0000,
    S_SCAN    = 8'b0010_0000,
    S_FC_RD   = 8'b0100_0000,
    S_FC_CHK  = 8'b1000_0000
  } state_e;

  function automatic logic [WORD_W-1:0] usable_mask(input logic [WA-1:0] w);
    logic [WORD_W-1:0] m;
    logic [17:0]       first;
    logic [17:0]       n;
    m     = '1;
    first = 18'(w) << 5;
    n     = '0;
    if (w == '0) begin
      m[WORD_W-1] = 1'b0;
    end
    if (first + 18'd32 > SLOTS_18) begin
      if (first >= SLOTS_18) begin
        m = '0;
      end else begin
        n = SLOTS_18 - first;
        m = m & ~(32'hFFFF_FFFF >> n[4:0]);
      end
    end
    return m;
  endfunction

  function automatic logic [4:0] lead_one(input logic [WORD_W-1:0] bits);
    logic [4:0] b;
    b = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (bits[i]) begin
        b = 5'(WORD_W - 1 - i);
      end
    end
    return b;
  endfunction

  logic [WORD_W-1:0] bm_mem [TOTAL];
  logic [CNT_W-1:0]  used_mem [POOLS];

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [ID_W-1:0]   rem_q, rem_d;
  logic [PW-1:0]     pool_q, pool_d;
  logic [BW-1:0]     base_q, base_d;
  logic [ID_W-1:0]   idb_q, idb_d;
  logic [WW-1:0]     word_q, word_d;
  logic              pend_q, pend_d;
  logic [WA-1:0]     pend_w_q, pend_w_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic              ok_q, ok_d;

  logic [WORD_W-1:0] bm_rd_q;
  logic [CNT_W-1:0]  used_rd_q;

  logic              bm_re, bm_we, used_re, used_we;
  logic [AW-1:0]     bm_raddr, bm_waddr;
  logic [WORD_W-1:0] bm_wdata;
  logic [PA-1:0]     used_raddr, used_waddr;
  logic [CNT_W-1:0]  used_wdata;

  logic [SW-1:0]     slot;
  logic [AW-1:0]     fc_addr;
  logic [WORD_W-1:0] fc_mask;
  logic              fc_free;
  logic [WORD_W-1:0] scan_bits;
  logic [4:0]        scan_b;
  logic [ID_W-1:0]   scan_slot;
  logic [ID_W-1:0]   scan_rid;
  logic              is_fc;

  assign slot      = rem_q[SW-1:0];
  assign fc_addr   = base_q[AW-1:0] + AW'(slot >> 5);
  assign fc_mask   = 32'h8000_0000 >> slot[4:0];
  assign fc_free   = |(bm_rd_q & fc_mask);
  assign scan_bits = bm_rd_q & usable_mask(pend_w_q);
  assign scan_b    = lead_one(scan_bits);
  assign scan_slot = (ID_W'(pend_w_q) << 5) | ID_W'(scan_b);
  assign scan_rid  = idb_q + scan_slot + ID_W'(1);
  assign is_fc     = (cmd_q.op == OP_FREE) || (cmd_q.op == OP_CLAIM);

  assign init_done_o = (state_q != S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign result_id_o = rid_q;
  assign ok_o        = ok_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rem_d       = rem_q;
    pool_d      = pool_q;
    base_d      = base_q;
    idb_d       = idb_q;
    word_d      = word_q;
    pend_d      = pend_q;
    pend_w_d    = pend_w_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rid_d       = rid_q;
    ok_d        = ok_q;
    cmd_pop_o   = 1'b0;
    bm_re       = 1'b0;
    bm_raddr    = fc_addr;
    bm_we       = 1'b0;
    bm_waddr    = fc_addr;
    bm_wdata    = bm_rd_q;
    used_re     = 1'b0;
    used_raddr  = pool_q[PA-1:0];
    used_we     = 1'b0;
    used_waddr  = pool_q[PA-1:0];
    used_wdata  = used_rd_q;

    case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = '1;
        if (clr_q < POOLS_A) begin
          used_we    = 1'b1;
          used_waddr = clr_q[PA-1:0];
          used_wdata = '0;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_A) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || out_ready_i)) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          rem_d     = cmd_i.vid;
          pool_d    = '0;
          base_d    = '0;
          idb_d     = '0;
          state_d   = (cmd_i.op == OP_ALLOC_ANY) ? S_CNT_RD : S_LOCATE;
        end
      end
      S_LOCATE: begin
        if ((is_fc && cmd_q.id_zero) || (pool_q == POOLS_V)) begin
          out_valid_d = 1'b1;
          rid_d       = '0;
          ok_d        = 1'b0;
          state_d     = S_IDLE;
        end else if (rem_q >= SLOTS_ID) begin
          rem_d  = rem_q - SLOTS_ID;
          pool_d = pool_q + PW'(1);
          base_d = base_q + WORDS_B;
          idb_d  = idb_q + SLOTS_ID;
        end else if (!is_fc) begin
          state_d = S_CNT_RD;
        end else if ((slot == '0) || (18'(slot >> 5) >= WORDS_18)) begin
          out_valid_d = 1'b1;
          rid_d       = '0;
          ok_d        = 1'b0;
          state_d     = S_IDLE;
        end else begin
          state_d = S_FC_RD;
        end
      end
      S_CNT_RD: begin
        if (pool_q == POOLS_V) begin
          out_valid_d = 1'b1;
          rid_d       = '0;
          ok_d        = 1'b0;
          state_d     = S_IDLE;
        end else begin
          used_re = 1'b1;
          state_d = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        if (17'(used_rd_q) >= FULL_CNT) begin
          pool_d  = pool_q + PW'(1);
          base_d  = base_q + WORDS_B;
          idb_d   = idb_q + SLOTS_ID;
          state_d = S_CNT_RD;
        end else begin
          word_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_q && (scan_bits != '0)) begin
          bm_we       = 1'b1;
          bm_waddr    = base_q[AW-1:0] + AW'(pend_w_q);
          bm_wdata    = bm_rd_q & ~(32'h8000_0000 >> scan_b);
          used_we     = 1'b1;
          used_wdata  = used_rd_q + CNT_W'(1);
          out_valid_d = 1'b1;
          rid_d       = scan_rid;
          ok_d        = (scan_rid != '0);
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end else if (word_q < WORDS_V) begin
          bm_re    = 1'b1;
          bm_raddr = base_q[AW-1:0] + AW'(word_q);
          pend_d   = 1'b1;
          pend_w_d = word_q[WA-1:0];
          word_d   = word_q + WW'(1);
        end else if (!pend_q) begin
          pool_d  = pool_q + PW'(1);
          base_d  = base_q + WORDS_B;
          idb_d   = idb_q + SLOTS_ID;
          state_d = S_CNT_RD;
        end else begin
          pend_d = 1'b0;
        end
      end
      S_FC_RD: begin
        bm_re   = 1'b1;
        used_re = 1'b1;
        state_d = S_FC_CHK;
      end
      S_FC_CHK: begin
        out_valid_d = 1'b1;
        rid_d       = '0;
        state_d     = S_IDLE;
        if (cmd_q.op == OP_CLAIM) begin
          ok_d = fc_free;
          if (fc_free) begin
            bm_we      = 1'b1;
            bm_wdata   = bm_rd_q & ~fc_mask;
            used_we    = 1'b1;
            used_wdata = used_rd_q + CNT_W'(1);
          end
        end else begin
          ok_d = !fc_free;
          if (!fc_free) begin
            bm_we      = 1'b1;
            bm_wdata   = bm_rd_q | fc_mask;
            used_we    = 1'b1;
            used_wdata = used_rd_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_re) begin
      bm_rd_q <= bm_mem[bm_raddr];
    end
  end

  // use-count memory
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_re) begin
      used_rd_q <= used_mem[used_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rem_q    <= rem_d;
    base_q   <= base_d;
    idb_q    <= idb_d;
    word_q   <= word_d;
    pend_w_q <= pend_w_d;
    rid_q    <= rid_d;
    ok_q     <= ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pool_q      <= '0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      pend_q      <= pend_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/pooled_bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// pooled_bitmap_id_allocator
// Identifier allocator over POOLS bitmap pools with per-pool use counts.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bitmap memory, one word a cycle, with
// in_ready_o low. Requests then go into a two-entry command queue and are
// executed one at a time by the engine. A free or claim first steps through
// the pools to the one that holds the id. An allocation reads the use count
// of each pool it visits and scans the bitmap words of a pool that is not
// full (single read port of the bitmap memory, one word a cycle).
module pooled_bitmap_id_allocator #(
  parameter int POOLS          = 31,
  parameter int SLOTS_PER_POOL = 32768,
  parameter int WORDS_PER_POOL = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pba_pkg::op_e             op_i,
  input  logic [pba_pkg::ID_W-1:0] id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [pba_pkg::ID_W-1:0] result_id_o,
  output logic                     ok_o
);
  import pba_pkg::*;

  front_stat_t stat;
  cmd_t        push_cmd, head_cmd;
  logic        push, pop, full, empty, init_done;

  assign stat.full      = full;
  assign stat.init_done = init_done;

  pba_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .id_i       (id_i),
    .stat_i     (stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  pba_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  pba_engine #(
    .POOLS          (POOLS),
    .SLOTS_PER_POOL (SLOTS_PER_POOL),
    .WORDS_PER_POOL (WORDS_PER_POOL)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_id_o (result_id_o),
    .ok_o        (ok_o)
  );

endmodule

// File: design/pba_checker.sv
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [pba_pkg::ID_W-1:0] result_id_o,
  input logic                     ok_o
);
  import pba_pkg::*;

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_id_o) && $stable(ok_o))
    else $error("result changed while stalled");

  a_id_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_id_o != '0) |-> ok_o)
    else $error("nonzero identifier without success");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result without a request");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'(CMD_DEPTH + 1))
    else $error("too many transactions in flight");

endmodule

bind pooled_bitmap_id_allocator pba_checker u_pba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_id_o (result_id_o),
  .ok_o        (ok_o)
);

// File: verif/grant_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grant_tracker
// Watches both channels of the pooled bitmap id allocator, keeps its own
// copy of the pool bitmaps and use counts, predicts the result of every
// accepted request and compares each returned result, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module grant_tracker #(
  parameter int POOLS = 31,
  parameter int SLOTS = 32768,
  parameter int WORDS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  pba_pkg::op_e             op_i,
  input  logic [pba_pkg::ID_W-1:0] id_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [pba_pkg::ID_W-1:0] result_id_i,
  input  logic                     ok_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import pba_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] rid;
    logic            ok;
  } grant_t;

  bit [WORD_W-1:0] free_words [POOLS*WORDS];
  bit [CNT_W-1:0]  pool_used [POOLS];
  grant_t          grants_due [$];

  function automatic bit [WORD_W-1:0] usable_bits(int unsigned word);
    bit [WORD_W-1:0] mask;
    int unsigned first, span;
    mask = '1;
    first = word * 32;
    if (word == 0) mask[31] = 1'b0;
    if (first + 32 > SLOTS) begin
      span = (first >= SLOTS) ? 0 : SLOTS - first;
      mask = (span == 0) ? '0 : mask & ~(32'hFFFF_FFFF >> span);
    end
    return mask;
  endfunction

  // lowest free slot of a pool, marked used; zero when none
  function automatic int unsigned take_slot(int unsigned pool);
    bit [WORD_W-1:0] bits;
    int unsigned base;
    if (pool_used[pool] >= SLOTS - 1) return 0;
    base = pool * WORDS;
    for (int unsigned w = 0; w < WORDS; w++) begin
      bits = free_words[base + w] & usable_bits(w);
      if (bits != '0) begin
        for (int b = 0; b < 32; b++) begin
          if (bits[31 - b]) begin
            free_words[base + w][31 - b] = 1'b0;
            pool_used[pool] = pool_used[pool] + 1'b1;
            return w * 32 + b;
          end
        end
      end
    end
    return 0;
  endfunction

  function automatic logic [ID_W-1:0] alloc_from(int unsigned start);
    int unsigned slot;
    for (int unsigned p = start; p < POOLS; p++) begin
      slot = take_slot(p);
      if (slot != 0) return ID_W'(p * SLOTS + slot + 1);
    end
    return '0;
  endfunction

  function automatic logic flip_slot(logic [ID_W-1:0] ident, logic claim);
    int unsigned v, pool, slot, idx, pos;
    if (ident == '0) return 1'b0;
    v = ident - 1;
    pool = v / SLOTS;
    slot = v % SLOTS;
    if (pool >= POOLS || slot == 0) return 1'b0;
    if ((slot >> 5) >= WORDS) return 1'b0;
    idx = pool * WORDS + (slot >> 5);
    pos = 31 - (slot & 31);
    if (claim) begin
      if (!free_words[idx][pos]) return 1'b0;
      free_words[idx][pos] = 1'b0;
      pool_used[pool] = pool_used[pool] + 1'b1;
    end else begin
      if (free_words[idx][pos]) return 1'b0;
      free_words[idx][pos] = 1'b1;
      pool_used[pool] = pool_used[pool] - 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic grant_t predict_grant(op_e kind, logic [ID_W-1:0] ident);
    grant_t g;
    int unsigned start;
    g.rid = '0;
    g.ok  = 1'b0;
    case (kind)
      OP_ALLOC_ANY: begin
        g.rid = alloc_from(0);
        g.ok  = (g.rid != '0);
      end
      OP_ALLOC_MIN: begin
        start = (ident == '0) ? 0 : (ident - 1) / SLOTS;
        if (start < POOLS) begin
          g.rid = alloc_from(start);
          g.ok  = (g.rid != '0);
        end
      end
      OP_FREE:  g.ok = flip_slot(ident, 1'b0);
      OP_CLAIM: g.ok = flip_slot(ident, 1'b1);
      default:  g.ok = 1'b0;
    endcase
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    grant_t due;
    if (!rst_ni) begin
      foreach (free_words[k]) free_words[k] = '1;
      foreach (pool_used[k]) pool_used[k] = '0;
      grants_due.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) grants_due.push_back(predict_grant(op_i, id_i));
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          $display("%0t unexpected transaction: result_id %0d ok %0b",
                   $time, result_id_i, ok_i);
          fail_count_o++;
        end else begin
          due = grants_due.pop_front();
          if (result_id_i !== due.rid) begin
            $display("%0t result_id mismatch: expected %0d, actual %0d",
                     $time, due.rid, result_id_i);
            fail_count_o++;
          end
          if (ok_i !== due.ok) begin
            $display("%0t ok mismatch: expected %0b, actual %0b", $time, due.ok, ok_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = grants_due.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the pooled bitmap id allocator with a directed set of edge cases
// followed by a random mix of allocate, free and claim requests focused on
// the low slots of pool 0, with random idling on both channels and one
// long output stall; the tracker module predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import pba_pkg::*;

  localparam int POOLS        = 31;
  localparam int SLOTS        = 32768;
  localparam int WORDS        = 1024;
  localparam int LAST_ID      = POOLS * SLOTS;
  localparam int RANDOM_ITEMS = 560;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 64;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  op_e             op        = OP_ALLOC_ANY;
  logic [ID_W-1:0] id        = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [ID_W-1:0] result_id;
  logic            ok;
  int              fail_count;
  int              pending;
  bit              held      = 1'b0;

  pooled_bitmap_id_allocator #(
    .POOLS(POOLS),
    .SLOTS_PER_POOL(SLOTS),
    .WORDS_PER_POOL(WORDS)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .op_i(op),
    .id_i(id),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .result_id_o(result_id),
    .ok_o(ok)
  );

  grant_tracker #(
    .POOLS(POOLS),
    .SLOTS(SLOTS),
    .WORDS(WORDS)
  ) tracker (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_i(in_ready),
    .op_i(op),
    .id_i(id),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .result_id_i(result_id),
    .ok_i(ok),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic issue(input op_e kind, input logic [ID_W-1:0] ident, input bit may_idle);
    if (may_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    id <= ident;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly low slots of pool 0 so frees and claims hit live ids
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned roll, pool, slot;
    roll = $urandom_range(99);
    if (roll < 8) return ID_W'($urandom());
    if (roll < 12) return ID_W'($urandom_range(LAST_ID + 1, 2**ID_W - 1));
    pool = ($urandom_range(3) == 0) ? $urandom_range(POOLS - 1) : 0;
    slot = ($urandom_range(15) == 0) ? $urandom_range(SLOTS - 1) : $urandom_range(160);
    return ID_W'(pool * SLOTS + slot + 1);
  endfunction

  initial begin : receiver
    int unsigned taken;
    taken = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!held && taken >= 150) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end
      out_ready <= (taken >= 300 && taken < 420) || ($urandom_range(99) >= 12);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned roll;
    bit          steady;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    issue(OP_ALLOC_ANY, '0, 1'b1);
    issue(OP_ALLOC_MIN, '0, 1'b1);
    issue(OP_ALLOC_MIN, ID_W'(1), 1'b1);
    issue(OP_ALLOC_MIN, ID_W'(SLOTS + 1), 1'b1);
    issue(OP_ALLOC_MIN, ID_W'(LAST_ID), 1'b1);
    issue(OP_ALLOC_MIN, ID_W'(LAST_ID + 1), 1'b1);
    issue(OP_ALLOC_MIN, '1, 1'b1);
    issue(OP_FREE, '0, 1'b1);
    issue(OP_CLAIM, '0, 1'b1);
    issue(OP_FREE, ID_W'(LAST_ID + 1), 1'b1);
    issue(OP_CLAIM, '1, 1'b1);
    issue(OP_FREE, ID_W'(1), 1'b1);
    issue(OP_CLAIM, ID_W'(SLOTS + 1), 1'b1);
    issue(OP_FREE, ID_W'(2), 1'b1);
    issue(OP_FREE, ID_W'(2), 1'b1);
    issue(OP_CLAIM, ID_W'(3), 1'b1);
    issue(OP_CLAIM, ID_W'(LAST_ID), 1'b1);
    issue(OP_FREE, ID_W'(LAST_ID), 1'b1);
    issue(OP_CLAIM, ID_W'(2), 1'b1);
    issue(OP_CLAIM, ID_W'(SLOTS), 1'b1);
    issue(OP_ALLOC_ANY, '0, 1'b1);
    issue(OP_FREE, ID_W'(SLOTS), 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 250 && i < 370);
      roll = $urandom_range(99);
      if (roll < 25) issue(OP_ALLOC_ANY, ID_W'($urandom()), !steady);
      else if (roll < 40) issue(OP_ALLOC_MIN, pick_id(), !steady);
      else if (roll < 70) issue(OP_FREE, pick_id(), !steady);
      else if (roll < 92) issue(OP_CLAIM, pick_id(), !steady);
      else issue(op_e'($urandom_range(3)), ID_W'($urandom()), !steady);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
